// File: rtl/shifted_interval_min_key_match_defines.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SHIFTED_INTERVAL_MIN_KEY_MATCH_DEFINES_SVH
`define SHIFTED_INTERVAL_MIN_KEY_MATCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIMKM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIMKM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/simkm_pkg.sv
package simkm_pkg;

    // Default sizes of the table and of the coordinate fields.
    localparam int unsigned SIMKM_ENTRIES    = 256;
    localparam int unsigned SIMKM_COORD_BITS = 30;
    localparam int unsigned SIMKM_ACT_BITS   = 2;

    // Action codes of an input word.
    typedef enum logic [SIMKM_ACT_BITS-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2
    } simkm_action_t;

    // Query token handed from cell to cell.
    typedef struct packed {
        logic valid;
        logic found;
    } simkm_tok_t;

endpackage

// File: rtl/simkm_in_if.sv
interface simkm_in_if
    import simkm_pkg::*;
#(
    parameter int unsigned COORD_BITS = SIMKM_COORD_BITS
);
    logic                      valid;
    logic                      ready;
    logic [SIMKM_ACT_BITS-1:0] action;
    logic [COORD_BITS-1:0]     seg_start;
    logic [COORD_BITS-1:0]     seg_end;
    logic [COORD_BITS-1:0]     seg_position;
    logic [COORD_BITS-1:0]     probe_time;

    modport source (
        output valid, action, seg_start, seg_end, seg_position, probe_time,
        input  ready
    );
    modport sink (
        input  valid, action, seg_start, seg_end, seg_position, probe_time,
        output ready
    );
endinterface

// File: rtl/simkm_out_if.sv
interface simkm_out_if
    import simkm_pkg::*;
#(
    parameter int unsigned COORD_BITS = SIMKM_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [COORD_BITS-1:0] best_position;

    modport source (
        output valid, hit, best_position,
        input  ready
    );
    modport sink (
        input  valid, hit, best_position,
        output ready
    );
endinterface

// File: rtl/simkm_cell.sv
// One table entry plus one stage of the query pipeline.
module simkm_cell
    import simkm_pkg::*;
#(
    parameter int unsigned COORD_BITS = SIMKM_COORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Table control, broadcast to every cell.
    input  logic                  shift,
    input  logic                  clr,
    // Entry handed in from the previous cell, and out to the next.
    input  logic                  ent_valid_in,
    input  logic [COORD_BITS:0]   ent_low_in,
    input  logic [COORD_BITS:0]   ent_high_in,
    input  logic [COORD_BITS-1:0] ent_key_in,
    output logic                  ent_valid_out,
    output logic [COORD_BITS:0]   ent_low_out,
    output logic [COORD_BITS:0]   ent_high_out,
    output logic [COORD_BITS-1:0] ent_key_out,
    // Query word travelling along the chain.
    input  simkm_tok_t            tok_in,
    input  logic [COORD_BITS-1:0] time_in,
    input  logic [COORD_BITS-1:0] best_in,
    output simkm_tok_t            tok_out,
    output logic [COORD_BITS-1:0] time_out,
    output logic [COORD_BITS-1:0] best_out
);

    logic                  ent_valid_reg, ent_valid_next;
    logic [COORD_BITS:0]   ent_low_reg;
    logic [COORD_BITS:0]   ent_high_reg;
    logic [COORD_BITS-1:0] ent_key_reg;
    simkm_tok_t            tok_reg, tok_next;
    logic [COORD_BITS-1:0] time_reg;
    logic [COORD_BITS-1:0] best_reg, best_next;

    logic [COORD_BITS:0]   t_ext;
    logic                  match;
    logic                  take;

    // Range test on the zero-extended time, then keep the smaller key.
    always_comb
    begin
        t_ext     = {1'b0, time_in};
        match     = tok_in.valid && ent_valid_reg
                    && ($signed(ent_low_reg) <= $signed(t_ext))
                    && ($signed(t_ext) < $signed(ent_high_reg));
        take      = match && (!tok_in.found || (ent_key_reg < best_in));
        tok_next  = '{valid: tok_in.valid, found: tok_in.found | match};
        best_next = take ? ent_key_reg : best_in;
    end

    // A clear empties the cell; a load shifts the neighbour's entry in.
    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (clr)
        begin
            ent_valid_next = 1'b0;
        end
        else if (shift)
        begin
            ent_valid_next = ent_valid_in;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            tok_reg       <= '0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            tok_reg       <= tok_next;
        end
    end

    // Entry and query payload.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ent_low_reg  <= ent_low_in;
            ent_high_reg <= ent_high_in;
            ent_key_reg  <= ent_key_in;
        end
        time_reg <= time_in;
        best_reg <= best_next;
    end

    assign ent_valid_out = ent_valid_reg;
    assign ent_low_out   = ent_low_reg;
    assign ent_high_out  = ent_high_reg;
    assign ent_key_out   = ent_key_reg;
    assign tok_out       = tok_reg;
    assign time_out      = time_reg;
    assign best_out      = best_reg;

endmodule

// File: rtl/shifted_interval_min_key_match.sv
// Minimum-key interval matcher. The table is a chain of ENTRIES cells. A load
// word shifts a new entry into the head of the chain and is dropped when the
// last cell already holds an entry; a clear word empties every cell. A query
// word travels down the chain one cell per cycle, each cell testing its range
// and keeping the smaller key, then passes a hold register into the output
// register; the block takes no further word until its result word is offered.
// Clear, load and unused action codes do not make the block busy and produce
// no result. A finished result waits in an output register, so the next word is
// accepted while the result has not yet been taken.
module shifted_interval_min_key_match
    import simkm_pkg::*;
#(
    parameter int unsigned ENTRIES    = SIMKM_ENTRIES,
    parameter int unsigned COORD_BITS = SIMKM_COORD_BITS
)
(
    input  logic           clk,
    input  logic           rst_n,
    simkm_in_if.sink       req,
    simkm_out_if.source    rsp
);

    // Chain links: index k feeds cell k, index ENTRIES is the tail.
    logic                  ent_valid_w [ENTRIES+1];
    logic [COORD_BITS:0]   ent_low_w   [ENTRIES+1];
    logic [COORD_BITS:0]   ent_high_w  [ENTRIES+1];
    logic [COORD_BITS-1:0] ent_key_w   [ENTRIES+1];
    simkm_tok_t            tok_w       [ENTRIES+1];
    logic [COORD_BITS-1:0] time_w      [ENTRIES+1];
    logic [COORD_BITS-1:0] best_w      [ENTRIES+1];

    logic                  accept;
    simkm_action_t         act;
    logic                  do_clear;
    logic                  do_load;
    logic                  do_query;
    logic                  full;
    logic                  move_out;

    logic                  busy_reg, busy_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic                  hold_hit_reg;
    logic [COORD_BITS-1:0] hold_best_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg;
    logic [COORD_BITS-1:0] out_best_reg;

    // Input decode.
    always_comb
    begin
        act      = simkm_action_t'(req.action);
        accept   = req.valid && req.ready;
        full     = ent_valid_w[ENTRIES];
        do_clear = accept && (act == ACT_CLEAR);
        do_load  = accept && (act == ACT_LOAD) && !full;
        do_query = accept && (act == ACT_QUERY);
    end

    // Head of the chain: the new shifted range and the entering query word.
    always_comb
    begin
        ent_valid_w[0] = 1'b1;
        ent_low_w[0]   = {1'b0, req.seg_start} - {1'b0, req.seg_position};
        ent_high_w[0]  = {1'b0, req.seg_end} - {1'b0, req.seg_position};
        ent_key_w[0]   = req.seg_position;
        tok_w[0]       = '{valid: do_query, found: 1'b0};
        time_w[0]      = req.probe_time;
        best_w[0]      = '0;
    end

    // The row of cells.
    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        simkm_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .shift         (do_load),
            .clr           (do_clear),
            .ent_valid_in  (ent_valid_w[k]),
            .ent_low_in    (ent_low_w[k]),
            .ent_high_in   (ent_high_w[k]),
            .ent_key_in    (ent_key_w[k]),
            .ent_valid_out (ent_valid_w[k+1]),
            .ent_low_out   (ent_low_w[k+1]),
            .ent_high_out  (ent_high_w[k+1]),
            .ent_key_out   (ent_key_w[k+1]),
            .tok_in        (tok_w[k]),
            .time_in       (time_w[k]),
            .best_in       (best_w[k]),
            .tok_out       (tok_w[k+1]),
            .time_out      (time_w[k+1]),
            .best_out      (best_w[k+1])
        );
    end

    // Result hand-off: tail of the chain into the hold stage, then the output.
    always_comb
    begin
        move_out        = hold_valid_reg && (!out_valid_reg || rsp.ready);
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg;
        busy_next       = busy_reg;
        if (tok_w[ENTRIES].valid)
        begin
            hold_valid_next = 1'b1;
        end
        else if (move_out)
        begin
            hold_valid_next = 1'b0;
        end
        if (move_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (do_query)
        begin
            busy_next = 1'b1;
        end
        else if (move_out)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_w[ENTRIES].valid)
        begin
            hold_hit_reg  <= tok_w[ENTRIES].found;
            hold_best_reg <= best_w[ENTRIES];
        end
        if (move_out)
        begin
            out_hit_reg  <= hold_hit_reg;
            out_best_reg <= hold_best_reg;
        end
    end

    assign req.ready         = !busy_reg;
    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.best_position = out_best_reg;

endmodule

// File: rtl/simkm_checker.sv
`include "shifted_interval_min_key_match_defines.svh"

// Port-level checks on the matcher.
module simkm_checker
    import simkm_pkg::*;
#(
    parameter int unsigned COORD_BITS = SIMKM_COORD_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_ready,
    input  logic [SIMKM_ACT_BITS-1:0] req_action,
    input  logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  logic                      rsp_hit,
    input  logic [COORD_BITS-1:0]     rsp_best_position
);

    logic req_take;
    logic is_query;

    assign req_take = req_valid && req_ready;
    assign is_query = (req_action == ACT_QUERY);

    // A stalled result word holds its value.
    `SIMKM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_best_position), "result word changed while stalled")

    // A miss reports a zero key.
    `SIMKM_ASSERT_SAME(a_miss_zero, rsp_valid && !rsp_hit, rsp_best_position == '0, "miss with non-zero key")

    // After a clear, load or unused code the block is ready again in the next cycle.
    `SIMKM_ASSERT_NEXT(a_quick_free, req_take && !is_query, req_ready, "block busy after a non-query word")

    // A query keeps the block busy while it travels the chain.
    `SIMKM_ASSERT_NEXT(a_query_busy, req_take && is_query, !req_ready, "word accepted during a query")

endmodule

bind shifted_interval_min_key_match simkm_checker #(
    .COORD_BITS (COORD_BITS)
) u_simkm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_action        (req.action),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_hit           (rsp.hit),
    .rsp_best_position (rsp.best_position)
);

// File: tb/sv/shifted_interval_min_key_match_tb.sv
module shifted_interval_min_key_match_tb;
    import simkm_pkg::*;

    localparam int unsigned ENTRIES    = SIMKM_ENTRIES;
    localparam int unsigned COORD_BITS = SIMKM_COORD_BITS;

    localparam logic [COORD_BITS-1:0]     COORD_MAX  = '1;
    localparam logic [COORD_BITS-1:0]     COORD_NONE = '0;
    localparam logic [SIMKM_ACT_BITS-1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned     RANDOM_ITEMS = 850;
    localparam int unsigned     QUIET_ITEMS  = 120;
    localparam int unsigned     FILL_PHASE   = 3;
    localparam int unsigned     PAUSE_PHASE  = 5;
    localparam int unsigned     HOLD_PHASE   = 8;
    localparam int unsigned     LONG_HOLD    = 3 * (ENTRIES + 2);
    localparam int unsigned     DRAIN_CYCLES = ENTRIES + 8;
    localparam int unsigned     REPORT_LIMIT = 10;
    localparam longint unsigned TIME_LIMIT   = 64'd30_000_000;

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] best_position;
    } match_t;

    typedef struct packed {
        logic [SIMKM_ACT_BITS-1:0] action;
        logic [COORD_BITS-1:0]     seg_start;
        logic [COORD_BITS-1:0]     seg_end;
        logic [COORD_BITS-1:0]     seg_position;
        logic [COORD_BITS-1:0]     probe_time;
        logic                      typed;
        match_t                    want;
    } stim_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    simkm_in_if  #(.COORD_BITS(COORD_BITS)) req_if ();
    simkm_out_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

    shifted_interval_min_key_match #(
        .ENTRIES    (ENTRIES),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the interval table, updated on every accepted clear and load word.
    logic signed [COORD_BITS:0] table_low  [ENTRIES];
    logic signed [COORD_BITS:0] table_high [ENTRIES];
    logic [COORD_BITS-1:0]      table_key  [ENTRIES];
    int unsigned                table_fill = 0;

    match_t      pending_matches [$];
    logic        offered_typed = 1'b0;
    match_t      offered_want  = '0;
    int unsigned mismatches    = 0;
    bit          idling_on     = 1'b0;
    bit          hold_request  = 1'b0;
    int unsigned random_sent   = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Smallest key among the stored ranges that contain the probe time.
    function automatic match_t min_key_lookup(input logic [COORD_BITS-1:0] probe);
        logic signed [COORD_BITS:0] t;
        match_t                     m;
        t = $signed({1'b0, probe});
        m = '0;
        for (int unsigned i = 0; i < table_fill; i++)
        begin
            if (table_low[i] <= t && t < table_high[i]
                && (!m.hit || table_key[i] < m.best_position))
            begin
                m.hit           = 1'b1;
                m.best_position = table_key[i];
            end
        end
        return m;
    endfunction

    task automatic report_mismatch(input string field, input logic [COORD_BITS-1:0] want,
                                   input logic [COORD_BITS-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // Track the table and queue the expected match for every accepted query.
    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
        begin
            case (req_if.action)
                ACT_CLEAR:
                    table_fill = 0;
                ACT_LOAD:
                    if (table_fill < ENTRIES)
                    begin
                        table_low[table_fill]  = $signed({1'b0, req_if.seg_start})
                                               - $signed({1'b0, req_if.seg_position});
                        table_high[table_fill] = $signed({1'b0, req_if.seg_end})
                                               - $signed({1'b0, req_if.seg_position});
                        table_key[table_fill]  = req_if.seg_position;
                        table_fill++;
                    end
                ACT_QUERY:
                    pending_matches.insert(pending_matches.size(),
                                           offered_typed ? offered_want
                                           : min_key_lookup(req_if.probe_time));
                default:
                    ;
            endcase
        end
    end

    // Compare each result word with the oldest expected match.
    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_matches.size() == 0)
            begin
                report_mismatch("result word with none pending, hit", COORD_NONE,
                                COORD_BITS'(rsp_if.hit));
            end
            else
            begin
                want = pending_matches.pop_front();
                if (rsp_if.hit !== want.hit)
                    report_mismatch("hit", COORD_BITS'(want.hit), COORD_BITS'(rsp_if.hit));
                if (rsp_if.best_position !== want.best_position)
                    report_mismatch("best_position", want.best_position,
                                    rsp_if.best_position);
            end
        end
    end

    // Result side: random short stalls, one long hold-off on request.
    initial
    begin
        rsp_if.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Offer one word at a falling edge and hold it until it is taken.
    task automatic send_word(input stim_word_t w);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        offered_typed = w.typed;
        offered_want  = w.want;
        req_if.valid        <= 1'b1;
        req_if.action       <= w.action;
        req_if.seg_start    <= w.seg_start;
        req_if.seg_end      <= w.seg_end;
        req_if.seg_position <= w.seg_position;
        req_if.probe_time   <= w.probe_time;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
        if (w.action != ACT_UNUSED)
            random_sent++;
    endtask

    function automatic stim_word_t dir_row(input logic [SIMKM_ACT_BITS-1:0] act,
                                           input logic [COORD_BITS-1:0] s,
                                           input logic [COORD_BITS-1:0] e,
                                           input logic [COORD_BITS-1:0] p,
                                           input logic [COORD_BITS-1:0] t,
                                           input logic typed, input logic hit,
                                           input logic [COORD_BITS-1:0] pos);
        stim_word_t w;
        w.action             = act;
        w.seg_start          = s;
        w.seg_end            = e;
        w.seg_position       = p;
        w.probe_time         = t;
        w.typed              = typed;
        w.want.hit           = hit;
        w.want.best_position = pos;
        return w;
    endfunction

    // A load whose shifted range start is drawn from [0, span], with a few reversed ones.
    function automatic stim_word_t random_load(input logic [COORD_BITS-1:0] span);
        stim_word_t            w;
        logic [COORD_BITS-1:0] low;
        logic [COORD_BITS-1:0] len;
        w              = '0;
        w.action       = ACT_LOAD;
        w.seg_position = COORD_BITS'($urandom_range(0, span));
        low            = COORD_BITS'($urandom_range(0, span));
        len            = COORD_BITS'($urandom_range(0, span / 4 + 1));
        w.seg_start    = low + w.seg_position;
        w.seg_end      = ($urandom_range(0, 9) == 0) ? w.seg_start - len : w.seg_start + len;
        w.probe_time   = COORD_BITS'($urandom);
        return w;
    endfunction

    // A query mostly within [0, span]; the load fields carry random junk.
    function automatic stim_word_t random_query(input logic [COORD_BITS-1:0] span);
        stim_word_t w;
        w              = '0;
        w.action       = ACT_QUERY;
        w.seg_start    = COORD_BITS'($urandom);
        w.seg_end      = COORD_BITS'($urandom);
        w.seg_position = COORD_BITS'($urandom);
        w.probe_time   = ($urandom_range(0, 9) == 0) ? COORD_BITS'($urandom)
                                                     : COORD_BITS'($urandom_range(0, span));
        return w;
    endfunction

    initial
    begin
        stim_word_t            directed [$];
        stim_word_t            w;
        logic [COORD_BITS-1:0] span;
        int unsigned           n_loads;
        int unsigned           n_queries;

        req_if.valid        = 1'b0;
        req_if.action       = ACT_CLEAR;
        req_if.seg_start    = '0;
        req_if.seg_end      = '0;
        req_if.seg_position = '0;
        req_if.probe_time   = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n     <= 1'b1;
        idling_on = 1'b1;

        // Directed words: empty table, reversed and empty ranges, extremes,
        // equal keys, the unused code and clearing.
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd7,
                                   1'b1, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_UNUSED, COORD_MAX, COORD_MAX,
                                   COORD_MAX, COORD_MAX, 1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, 30'd10, 30'd20, 30'd5, 30'd0,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd5,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd15,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd14,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, 30'd30, 30'd30, 30'd0, 30'd0,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd30,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, 30'd20, 30'd10, 30'd0, 30'd0,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd12,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, 30'd0, COORD_MAX, COORD_MAX,
                                   30'd0, 1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, COORD_MAX, COORD_MAX, 30'd0,
                                   30'd0, 1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, 30'd0, COORD_MAX, 30'd0, 30'd0,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0,
                                   COORD_MAX, 1'b1, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd0,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, 30'd100, 30'd200, 30'd5, 30'd0,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd100,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_CLEAR, COORD_MAX, COORD_MAX,
                                   COORD_MAX, COORD_MAX, 1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd0,
                                   1'b1, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, 30'd0, COORD_MAX,
                                   COORD_MAX - 30'd1, 30'd0, 1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0, 30'd0,
                                   1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_LOAD, COORD_MAX, COORD_MAX,
                                   COORD_MAX, 30'd0, 1'b0, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_QUERY, 30'd0, 30'd0, 30'd0,
                                   COORD_MAX, 1'b1, 1'b0, COORD_NONE));
        directed.insert(directed.size(), dir_row(ACT_CLEAR, 30'd0, 30'd0, 30'd0, 30'd0,
                                   1'b0, 1'b0, COORD_NONE));
        foreach (directed[i])
            send_word(directed[i]);

        // Random phases: usually a clear, a batch of loads, then queries, with
        // stray words mixed in. One phase overfills the table.
        random_sent = 0;
        for (int unsigned phase = 0; random_sent < RANDOM_ITEMS; phase++)
        begin
            if (random_sent + QUIET_ITEMS >= RANDOM_ITEMS)
                idling_on = 1'b0;
            span = ($urandom_range(0, 3) == 0) ? COORD_MAX
                                               : COORD_BITS'($urandom_range(16, 4095));

            // Stop offering until every outstanding match has come back.
            if (phase == PAUSE_PHASE)
            begin
                req_if.valid <= 1'b0;
                wait (pending_matches.size() == 0);
                @(negedge clk);
            end
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;

            if (phase == FILL_PHASE || $urandom_range(0, 7) != 0)
            begin
                w        = random_query(COORD_MAX);
                w.action = ACT_CLEAR;
                send_word(w);
            end

            n_loads = (phase == FILL_PHASE) ? ENTRIES + 4 : $urandom_range(1, 24);
            repeat (n_loads)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    w = random_query(span);
                    if ($urandom_range(0, 2) != 0)
                        w.action = ACT_UNUSED;
                    send_word(w);
                end
                send_word(random_load(span));
            end

            n_queries = (phase == HOLD_PHASE) ? 6 : $urandom_range(2, 8);
            repeat (n_queries)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(random_load(span));
                send_word(random_query(span));
            end
        end

        // Drain the outstanding matches, then allow for one more query's latency.
        req_if.valid <= 1'b0;
        wait (pending_matches.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIME_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: shifted_interval_min_key_match.f
+incdir+rtl
rtl/simkm_pkg.sv
rtl/simkm_in_if.sv
rtl/simkm_out_if.sv
rtl/simkm_cell.sv
rtl/shifted_interval_min_key_match.sv
rtl/simkm_checker.sv
tb/sv/shifted_interval_min_key_match_tb.sv
